[rtl/core/ktis_pkg.sv]
// Shared types and constants for the key table (insert, delete, search).
// Used by every module under rtl/core; depends on nothing.
package ktis_pkg;

    // default sizes handed to the top-level parameters
    localparam int DEF_CAPACITY = 256;
    localparam int DEF_KEY_BITS = 64;

    // match vector is encoded in groups of this many cells
    localparam int GROUP_SIZE = 16;

    // fixed field widths of the stream items
    localparam int OPCODE_W = 2;
    localparam int IN_KEY_W = 64;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REPLACE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;  // compare stored key against the search key
        logic ins;  // write the key into the cell at the fill position
        logic del;  // take the neighbor's key at and above the hit position
        logic rep;  // overwrite the key at the hit position
    } t_cell_ctl;

endpackage

[rtl/core/key_table_insert_delete_search.sv]
// Top level of the packed key table: stream ports, sequencer, cell chain.
// Depends on ktis_pkg, ktis_cell and ktis_prio_enc.
//
//  channel   | dir | handshake                    | payload (lowest bit first)
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: opcode[1:0]
//            |     |                              | tdata: key[63:0], new_key[127:64]
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: status[2:0], position[10:3],
//            |     |                              |        count[19:11], zeros[23:20]
//
// Each item goes through these steps in order: accept, compare in every cell,
// encode the match groups, then pick the hit, update the chain and load the
// result register. The chain compares and shifts all entries at once, so the
// steps do not depend on the fill level; the match register and the encoder's
// registered group stage separate them.
// A result still waiting on m_axis holds the update stage for as long as
// m_axis_tready stays low; once an item commits, the next one is taken even
// while its result waits in the output register.
// Reset (synchronous, active low) clears the count and the control state;
// the stored keys are left as they are and are never read before written.
module key_table_insert_delete_search #(
    parameter int CAPACITY = ktis_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = ktis_pkg::DEF_KEY_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    s_axis_tuser,   // opcode[1:0]
    input  logic [127:0]  s_axis_tdata,   // key[63:0], new_key[127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [23:0]   m_axis_tdata    // status[2:0], position[10:3], count[19:11]
);
    import ktis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OUT_W = STATUS_W + POS_W + COUNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_GRP  = 4'b0100,
        S_SEL  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [OPCODE_W-1:0]  r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  r_nkey;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;

    logic                 accept;
    logic                 commit;
    logic                 found;
    logic [IDX_W-1:0]     hit_pos;
    logic [IDX_W-1:0]     n_pos;
    logic [STATUS_W-1:0]  n_status;
    logic                 do_ins, do_del, do_rep;
    t_cell_ctl            cell_ctl;
    logic [KEY_BITS-1:0]  wr_key;
    logic [KEY_BITS-1:0]  cell_key [CAPACITY];
    logic [CAPACITY-1:0]  cell_match;

    // take a new item only between items; the output register decouples m_axis
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // finish an item once the result register is free
    assign commit        = (r_state == S_SEL) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CMP;
            S_CMP:   n_state = S_GRP;
            S_GRP:   n_state = S_SEL;
            S_SEL:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the item; key bits above KEY_BITS drop here
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_axis_tuser;
            r_key  <= s_axis_tdata[KEY_BITS-1:0];
            r_nkey <= s_axis_tdata[IN_KEY_W + KEY_BITS - 1:IN_KEY_W];
        end
    end

    // decide status, position and the chain update for this item
    always_comb begin
        n_status = ST_OK;
        n_pos    = '0;
        n_count  = r_count;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_rep   = 1'b0;
        if (r_op == OP_INSERT) begin
            if (r_count == FULL_CNT) begin
                n_status = ST_FULL;
            end else if (found) begin
                n_status = ST_DUP;
                n_pos    = hit_pos;
            end else begin
                n_pos    = r_count[IDX_W-1:0];
                n_count  = r_count + CNT_W'(1);
                do_ins   = 1'b1;
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (!found) begin
            n_status = ST_NOTFOUND;
        end else begin
            n_pos = hit_pos;
            if (r_op == OP_DELETE) begin
                n_count = r_count - CNT_W'(1);
                do_del  = 1'b1;
            end else if (r_op == OP_REPLACE) begin
                do_rep  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (commit) begin
            r_count <= n_count;
        end
    end

    // result register: load on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (commit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_m_data <= {COUNT_W'(n_count), POS_W'(n_pos), n_status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = 24'(r_m_data);

    // broadcast to the chain
    assign cell_ctl.cmp = (r_state == S_CMP);
    assign cell_ctl.ins = commit && do_ins;
    assign cell_ctl.del = commit && do_del;
    assign cell_ctl.rep = commit && do_rep;
    assign wr_key       = (r_op == OP_REPLACE) ? r_nkey : r_key;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0] next_key;
        if (i == CAPACITY - 1) begin : g_top
            assign next_key = '0;
        end else begin : g_mid
            assign next_key = cell_key[i+1];
        end
        ktis_cell #(
            .CAPACITY (CAPACITY),
            .KEY_BITS (KEY_BITS),
            .IDX      (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_key      (r_key),
            .i_wr_key   (wr_key),
            .i_next_key (next_key),
            .i_count    (r_count),
            .i_pos      (n_pos),
            .o_key      (cell_key[i]),
            .o_match    (cell_match[i])
        );
    end

    ktis_prio_enc #(
        .CAPACITY (CAPACITY)
    ) u_prio_enc (
        .i_clk   (i_clk),
        .i_en    (r_state == S_GRP),
        .i_match (cell_match),
        .o_found (found),
        .o_pos   (hit_pos)
    );

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // an accepted item starts the compare pass in the next cycle
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CMP))
        else $error("accepted item did not enter compare");

    // a good insert grows the table by one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && do_ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance the count");

    // an empty status comes only from an empty table
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (n_status == ST_EMPTY)) |-> (r_count == '0))
        else $error("empty status with entries present");

endmodule

[rtl/core/ktis_cell.sv]
// One table cell: stores a key, compares it, and takes its upper neighbor's
// key on delete. Depends on ktis_pkg.
module ktis_cell #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 64,
    parameter int IDX      = 0
) (
    input  logic                                  i_clk,
    input  ktis_pkg::t_cell_ctl                   i_ctl,
    input  logic [KEY_BITS-1:0]                   i_key,
    input  logic [KEY_BITS-1:0]                   i_wr_key,
    input  logic [KEY_BITS-1:0]                   i_next_key,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_count,
    input  logic [$clog2(CAPACITY)-1:0]           i_pos,
    output logic [KEY_BITS-1:0]                   o_key,
    output logic                                  o_match
);
    import ktis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_BITS-1:0] r_key;
    logic                r_match;
    logic                occupied;

    // entries are packed, so the cell is live when it sits below the count
    assign occupied = (MY_CNT < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= occupied && (r_key == i_key);
        end
        if (i_ctl.ins && (MY_CNT == i_count)) begin
            r_key <= i_wr_key;
        end else if (i_ctl.rep && (MY_IDX == i_pos)) begin
            r_key <= i_wr_key;
        end else if (i_ctl.del && (MY_IDX >= i_pos)) begin
            r_key <= i_next_key;
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

[rtl/core/ktis_prio_enc.sv]
// Two-level lowest-hit encoder over the cell match vector: group results are
// registered, the group pick is combinational. Depends on ktis_pkg.
module ktis_prio_enc #(
    parameter int CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [CAPACITY-1:0]           i_match,
    output logic                          o_found,
    output logic [$clog2(CAPACITY)-1:0]   o_pos
);
    import ktis_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int NGRP   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GIDX_W = $clog2(GROUP_SIZE);
    localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W  = NGRP * GROUP_SIZE;

    logic [PAD_W-1:0]  match_pad;
    logic [NGRP-1:0]   n_any;
    logic [GIDX_W-1:0] n_loc [NGRP];
    logic [NGRP-1:0]   r_any;
    logic [GIDX_W-1:0] r_loc [NGRP];
    logic [GSEL_W-1:0] sel_grp;
    logic [GIDX_W-1:0] sel_loc;
    logic              found;

    assign match_pad = PAD_W'(i_match);

    // lowest hit inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_any[g] = 1'b0;
            n_loc[g] = '0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
                if (match_pad[g*GROUP_SIZE + j]) begin
                    n_any[g] = 1'b1;
                    n_loc[g] = GIDX_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_any <= n_any;
            for (int g = 0; g < NGRP; g++) begin
                r_loc[g] <= n_loc[g];
            end
        end
    end

    // lowest group that holds a hit
    always_comb begin
        found   = 1'b0;
        sel_grp = '0;
        sel_loc = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                found   = 1'b1;
                sel_grp = GSEL_W'(g);
                sel_loc = r_loc[g];
            end
        end
    end

    assign o_found = found;
    assign o_pos   = IDX_W'({sel_grp, sel_loc});

endmodule
